[hw/rtl/p2s_pkg.sv]
// Shared types, constants and the arctangent table for the squarize datapath.
package p2s_pkg;

    localparam int COORD_BITS = 32;
    localparam int GUARD_BITS = 12;
    localparam int ANG_BITS   = 32;
    localparam int MUL_B_BITS = 32;
    // Working width of the rotation datapath: coordinate, guard bits and growth headroom.
    localparam int XW         = COORD_BITS + GUARD_BITS + 3;
    localparam int MAX_STEPS  = 32;

    localparam int GAIN_SHIFT   = 30;
    localparam int OCTANT_SHIFT = 29;
    localparam logic signed [MUL_B_BITS-1:0] INV_GAIN = 32'sd652032874;

    localparam logic [ANG_BITS-1:0] ANG_ZERO = 32'h0000_0000;
    localparam logic [ANG_BITS-1:0] ANG_PI   = 32'h8000_0000;
    localparam logic [ANG_BITS-1:0] OCT_1    = 32'h2000_0000;
    localparam logic [ANG_BITS-1:0] OCT_3    = 32'h6000_0000;
    localparam logic [ANG_BITS-1:0] OCT_5    = 32'hA000_0000;
    localparam logic [ANG_BITS-1:0] OCT_7    = 32'hE000_0000;
    localparam logic signed [ANG_BITS+1:0] OCT_2_W = 34'sh0_4000_0000;
    localparam logic signed [ANG_BITS+1:0] OCT_4_W = 34'sh0_8000_0000;
    localparam logic signed [ANG_BITS+1:0] OCT_6_W = 34'sh0_C000_0000;
    localparam logic signed [ANG_BITS+1:0] OCT_8_W = 34'sh1_0000_0000;

    localparam logic signed [COORD_BITS-1:0] SAT_HI = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam logic signed [COORD_BITS-1:0] SAT_LO = {1'b1, {(COORD_BITS-1){1'b0}}};

    typedef struct packed {
        logic signed [COORD_BITS-1:0] point_x;
        logic signed [COORD_BITS-1:0] point_y;
        logic signed [COORD_BITS-1:0] point_z;
        logic signed [COORD_BITS-1:0] acc_in_x;
        logic signed [COORD_BITS-1:0] acc_in_y;
        logic signed [COORD_BITS-1:0] acc_in_z;
    } t_in;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] acc_out_x;
        logic signed [COORD_BITS-1:0] acc_out_y;
        logic signed [COORD_BITS-1:0] acc_out_z;
    } t_out;

    // Values that ride alongside the rotation without being touched by it.
    typedef struct packed {
        logic signed [COORD_BITS-1:0] point_z;
        logic signed [COORD_BITS-1:0] acc_x;
        logic signed [COORD_BITS-1:0] acc_y;
        logic signed [COORD_BITS-1:0] acc_z;
    } t_side;

    typedef struct packed {
        logic                 valid;
        logic                 axis;
        logic [ANG_BITS-1:0]  ang;
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
    } t_cordic;

    // Angle of atan(2^-i) with a full turn equal to 2^32.
    function automatic logic [ANG_BITS-1:0] atan_entry(input logic [4:0] idx);
        logic [ANG_BITS-1:0] v;
        unique case (idx)
            5'd0:  v = 32'h2000_0000;
            5'd1:  v = 32'h12E4_051E;
            5'd2:  v = 32'h09FB_385B;
            5'd3:  v = 32'h0511_11D4;
            5'd4:  v = 32'h028B_0D43;
            5'd5:  v = 32'h0145_D7E1;
            5'd6:  v = 32'h00A2_F61E;
            5'd7:  v = 32'h0051_7C55;
            5'd8:  v = 32'h0028_BE53;
            5'd9:  v = 32'h0014_5F2F;
            5'd10: v = 32'h000A_2F98;
            5'd11: v = 32'h0005_17CC;
            5'd12: v = 32'h0002_8BE6;
            5'd13: v = 32'h0001_45F3;
            5'd14: v = 32'h0000_A2FA;
            5'd15: v = 32'h0000_517D;
            5'd16: v = 32'h0000_28BE;
            5'd17: v = 32'h0000_145F;
            5'd18: v = 32'h0000_0A30;
            5'd19: v = 32'h0000_0518;
            5'd20: v = 32'h0000_028C;
            5'd21: v = 32'h0000_0146;
            5'd22: v = 32'h0000_00A3;
            5'd23: v = 32'h0000_0051;
            5'd24: v = 32'h0000_0029;
            5'd25: v = 32'h0000_0014;
            5'd26: v = 32'h0000_000A;
            5'd27: v = 32'h0000_0005;
            5'd28: v = 32'h0000_0003;
            5'd29: v = 32'h0000_0001;
            5'd30: v = 32'h0000_0001;
            5'd31: v = 32'h0000_0000;
        endcase
        return v;
    endfunction

endpackage

[hw/rtl/polar_to_square_boundary_map_core.sv]
// Top level: squarize map of a point onto the square of its radius, with weighted accumulation.
//
// One point is accepted per clock cycle while o_in_stall is low. Each point passes through
// a register that folds it into the right half plane, one register per cell of the vectoring
// chain, the registers of the three pipelined multiplies (gain removal, octant scaling, weight)
// with a band-select register and a mapping register between them, and the output register.
// A skid register behind the output register takes one more result while o_out_data is
// stalled; o_in_stall rises only once that skid register is occupied. The weight register is
// written through i_cfg_we / i_cfg_wdata and resets to 1.0 in Q(FRAC_BITS); write it only
// while no transfer is in flight.
module polar_to_square_boundary_map_core #(
    parameter int FRAC_BITS    = 16,
    parameter int CORDIC_STEPS = 20
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  p2s_pkg::t_in                         i_in_data,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output p2s_pkg::t_out                        o_out_data,
    input  logic                                 i_cfg_we,
    input  logic signed [p2s_pkg::COORD_BITS-1:0] i_cfg_wdata
);
    import p2s_pkg::*;

    localparam int K_XY  = FRAC_BITS + GUARD_BITS;
    localparam int K_Z   = FRAC_BITS;
    localparam int RW_S  = XW + MUL_B_BITS - GAIN_SHIFT;
    localparam int RW_M  = XW + MUL_B_BITS - OCTANT_SHIFT;
    localparam int RW_XY = XW + MUL_B_BITS - K_XY;
    localparam int RW_Z  = COORD_BITS + MUL_B_BITS - K_Z;
    localparam logic signed [COORD_BITS-1:0] WEIGHT_RESET =
        COORD_BITS'(64'd1 << FRAC_BITS);

    typedef enum logic [2:0] {
        BAND_EAST_LO,
        BAND_NORTH,
        BAND_WEST,
        BAND_SOUTH,
        BAND_EAST_HI
    } t_band;

    logic en;
    logic accept;

    logic signed [COORD_BITS-1:0] r_weight;

    // Half-plane fold ahead of the chain.
    logic signed [XW-1:0] pre_x;
    logic signed [XW-1:0] pre_y;
    t_cordic              n_pre;
    t_cordic              r_pre;
    t_side                n_pre_side;
    t_side                r_pre_side;

    t_cordic c_st   [0:CORDIC_STEPS];
    t_side   c_side [0:CORDIC_STEPS];

    // Gain removal stages.
    logic signed [RW_S-1:0] s_scaled;
    logic                   r_s1_valid, r_s2_valid;
    logic                   r_s1_axis, r_s2_axis;
    logic [ANG_BITS-1:0]    r_s1_ang, r_s2_ang;
    logic signed [XW-1:0]   r_s1_x, r_s2_x;
    t_side                  r_s1_side, r_s2_side;

    // Band select stage.
    logic signed [XW-1:0]         b_s;
    logic signed [ANG_BITS+1:0]   b_f_wide;
    logic signed [ANG_BITS+1:0]   b_ang_wide;
    t_band                        b_band;
    logic                         r_b_valid;
    logic signed [XW-1:0]         r_b_s;
    logic signed [MUL_B_BITS-1:0] r_b_f;
    t_band                        r_b_band;
    t_side                        r_b_side;

    // Octant scaling stages.
    logic signed [RW_M-1:0] m_full;
    logic                   r_m1_valid, r_m2_valid;
    logic signed [XW-1:0]   r_m1_s, r_m2_s;
    t_band                  r_m1_band, r_m2_band;
    t_side                  r_m1_side, r_m2_side;

    // Mapping stage.
    logic signed [XW-1:0] m_val;
    logic signed [XW-1:0] n_cx;
    logic signed [XW-1:0] n_cy;
    logic                 r_c_valid;
    logic signed [XW-1:0] r_c_x;
    logic signed [XW-1:0] r_c_y;
    t_side                r_c_side;

    // Weight stages and accumulation.
    logic signed [RW_XY-1:0] w_px;
    logic signed [RW_XY-1:0] w_py;
    logic signed [RW_Z-1:0]  w_pz;
    logic                    r_w1_valid, r_w2_valid;
    t_side                   r_w1_side, r_w2_side;
    logic signed [RW_XY:0]   sum_x;
    logic signed [RW_XY:0]   sum_y;
    logic signed [RW_Z:0]    sum_z;
    t_out                    n_res;
    logic                    arrive;

    t_out r_out;
    logic r_out_valid;
    t_out r_skid;
    logic r_skid_valid;
    logic out_take;

    // The whole pipeline holds only while the skid register is occupied.
    assign en         = !r_skid_valid;
    assign accept     = i_in_valid && en;
    assign o_in_stall = r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weight <= WEIGHT_RESET;
        end else if (i_cfg_we) begin
            r_weight <= i_cfg_wdata;
        end
    end

    assign pre_x = XW'(i_in_data.point_x) <<< GUARD_BITS;
    assign pre_y = XW'(i_in_data.point_y) <<< GUARD_BITS;

    always_comb begin
        n_pre.valid = accept;
        n_pre.axis  = (i_in_data.point_y == '0);
        n_pre.ang   = ANG_ZERO;
        n_pre.x     = pre_x;
        n_pre.y     = pre_y;
        if (n_pre.axis) begin
            // On the x axis the radius is |x| and the angle is 0 or pi.
            n_pre.y = '0;
            if (pre_x[XW-1]) begin
                n_pre.ang = ANG_PI;
                n_pre.x   = -pre_x;
            end
        end else if (pre_x[XW-1]) begin
            n_pre.ang = ANG_PI;
            n_pre.x   = -pre_x;
            n_pre.y   = -pre_y;
        end
        n_pre_side.point_z = i_in_data.point_z;
        n_pre_side.acc_x   = i_in_data.acc_in_x;
        n_pre_side.acc_y   = i_in_data.acc_in_y;
        n_pre_side.acc_z   = i_in_data.acc_in_z;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pre.valid <= 1'b0;
        end else if (en) begin
            r_pre      <= n_pre;
            r_pre_side <= n_pre_side;
        end
    end

    assign c_st[0]   = r_pre;
    assign c_side[0] = r_pre_side;

    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cell
        p2s_cordic_cell #(
            .STEP (k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_st    (c_st[k]),
            .i_side  (c_side[k]),
            .o_st    (c_st[k+1]),
            .o_side  (c_side[k+1])
        );
    end

    p2s_mul_round #(
        .AW (XW),
        .BW (MUL_B_BITS),
        .K  (GAIN_SHIFT)
    ) u_mul_gain (
        .i_clk (i_clk),
        .i_en  (en),
        .i_a   (c_st[CORDIC_STEPS].x),
        .i_b   (INV_GAIN),
        .o_p   (s_scaled)
    );

    assign b_s        = r_s2_axis ? r_s2_x : s_scaled[XW-1:0];
    assign b_ang_wide = $signed({2'b00, r_s2_ang});

    always_comb begin
        priority if (r_s2_ang <= OCT_1) begin
            b_band   = BAND_EAST_LO;
            b_f_wide = b_ang_wide;
        end else if (r_s2_ang <= OCT_3) begin
            b_band   = BAND_NORTH;
            b_f_wide = OCT_2_W - b_ang_wide;
        end else if (r_s2_ang <= OCT_5) begin
            b_band   = BAND_WEST;
            b_f_wide = OCT_4_W - b_ang_wide;
        end else if (r_s2_ang <= OCT_7) begin
            b_band   = BAND_SOUTH;
            b_f_wide = OCT_6_W - b_ang_wide;
        end else begin
            b_band   = BAND_EAST_HI;
            b_f_wide = OCT_8_W - b_ang_wide;
        end
    end

    p2s_mul_round #(
        .AW (XW),
        .BW (MUL_B_BITS),
        .K  (OCTANT_SHIFT)
    ) u_mul_oct (
        .i_clk (i_clk),
        .i_en  (en),
        .i_a   (r_b_s),
        .i_b   (r_b_f),
        .o_p   (m_full)
    );

    assign m_val = m_full[XW-1:0];

    always_comb begin
        unique case (r_m2_band)
            BAND_EAST_LO: begin
                n_cx = r_m2_s;
                n_cy = m_val;
            end
            BAND_NORTH: begin
                n_cx = m_val;
                n_cy = r_m2_s;
            end
            BAND_WEST: begin
                n_cx = -r_m2_s;
                n_cy = m_val;
            end
            BAND_SOUTH: begin
                n_cx = -m_val;
                n_cy = -r_m2_s;
            end
            BAND_EAST_HI: begin
                n_cx = r_m2_s;
                n_cy = -m_val;
            end
            default: begin
                n_cx = r_m2_s;
                n_cy = m_val;
            end
        endcase
    end

    p2s_mul_round #(
        .AW (XW),
        .BW (MUL_B_BITS),
        .K  (K_XY)
    ) u_mul_wx (
        .i_clk (i_clk),
        .i_en  (en),
        .i_a   (r_c_x),
        .i_b   (r_weight),
        .o_p   (w_px)
    );

    p2s_mul_round #(
        .AW (XW),
        .BW (MUL_B_BITS),
        .K  (K_XY)
    ) u_mul_wy (
        .i_clk (i_clk),
        .i_en  (en),
        .i_a   (r_c_y),
        .i_b   (r_weight),
        .o_p   (w_py)
    );

    p2s_mul_round #(
        .AW (COORD_BITS),
        .BW (MUL_B_BITS),
        .K  (K_Z)
    ) u_mul_wz (
        .i_clk (i_clk),
        .i_en  (en),
        .i_a   (r_c_side.point_z),
        .i_b   (r_weight),
        .o_p   (w_pz)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_b_valid  <= 1'b0;
            r_m1_valid <= 1'b0;
            r_m2_valid <= 1'b0;
            r_c_valid  <= 1'b0;
            r_w1_valid <= 1'b0;
            r_w2_valid <= 1'b0;
        end else if (en) begin
            r_s1_valid <= c_st[CORDIC_STEPS].valid;
            r_s2_valid <= r_s1_valid;
            r_b_valid  <= r_s2_valid;
            r_m1_valid <= r_b_valid;
            r_m2_valid <= r_m1_valid;
            r_c_valid  <= r_m2_valid;
            r_w1_valid <= r_c_valid;
            r_w2_valid <= r_w1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_axis <= c_st[CORDIC_STEPS].axis;
            r_s1_ang  <= c_st[CORDIC_STEPS].ang;
            r_s1_x    <= c_st[CORDIC_STEPS].x;
            r_s1_side <= c_side[CORDIC_STEPS];
            r_s2_axis <= r_s1_axis;
            r_s2_ang  <= r_s1_ang;
            r_s2_x    <= r_s1_x;
            r_s2_side <= r_s1_side;
            r_b_s     <= b_s;
            r_b_f     <= b_f_wide[MUL_B_BITS-1:0];
            r_b_band  <= b_band;
            r_b_side  <= r_s2_side;
            r_m1_s    <= r_b_s;
            r_m1_band <= r_b_band;
            r_m1_side <= r_b_side;
            r_m2_s    <= r_m1_s;
            r_m2_band <= r_m1_band;
            r_m2_side <= r_m1_side;
            r_c_x     <= n_cx;
            r_c_y     <= n_cy;
            r_c_side  <= r_m2_side;
            r_w1_side <= r_c_side;
            r_w2_side <= r_w1_side;
        end
    end

    assign sum_x = (RW_XY+1)'(r_w2_side.acc_x) + (RW_XY+1)'(w_px);
    assign sum_y = (RW_XY+1)'(r_w2_side.acc_y) + (RW_XY+1)'(w_py);
    assign sum_z = (RW_Z+1)'(r_w2_side.acc_z) + (RW_Z+1)'(w_pz);

    always_comb begin
        if (sum_x > (RW_XY+1)'(SAT_HI)) begin
            n_res.acc_out_x = SAT_HI;
        end else if (sum_x < (RW_XY+1)'(SAT_LO)) begin
            n_res.acc_out_x = SAT_LO;
        end else begin
            n_res.acc_out_x = sum_x[COORD_BITS-1:0];
        end
        if (sum_y > (RW_XY+1)'(SAT_HI)) begin
            n_res.acc_out_y = SAT_HI;
        end else if (sum_y < (RW_XY+1)'(SAT_LO)) begin
            n_res.acc_out_y = SAT_LO;
        end else begin
            n_res.acc_out_y = sum_y[COORD_BITS-1:0];
        end
        if (sum_z > (RW_Z+1)'(SAT_HI)) begin
            n_res.acc_out_z = SAT_HI;
        end else if (sum_z < (RW_Z+1)'(SAT_LO)) begin
            n_res.acc_out_z = SAT_LO;
        end else begin
            n_res.acc_out_z = sum_z[COORD_BITS-1:0];
        end
    end

    assign arrive   = en && r_w2_valid;
    assign out_take = r_out_valid && !i_out_stall;

    // A result that finds the output register busy and stalled waits in the skid register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_take) begin
                r_out        <= r_skid;
                r_skid_valid <= 1'b0;
            end
        end else if (arrive) begin
            if (!r_out_valid || out_take) begin
                r_out       <= n_res;
                r_out_valid <= 1'b1;
            end else begin
                r_skid       <= n_res;
                r_skid_valid <= 1'b1;
            end
        end else if (out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

[hw/rtl/p2s_cordic_cell.sv]
// One vectoring step of the rotation chain, with its own pipeline register.
module p2s_cordic_cell #(
    parameter int STEP = 0
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  p2s_pkg::t_cordic i_st,
    input  p2s_pkg::t_side   i_side,
    output p2s_pkg::t_cordic o_st,
    output p2s_pkg::t_side   o_side
);
    import p2s_pkg::*;

    localparam logic [ANG_BITS-1:0] ATAN = atan_entry(5'(STEP));

    logic signed [XW-1:0] dx;
    logic signed [XW-1:0] dy;
    t_cordic              n_st;
    t_cordic              r_st;
    t_side                r_side;

    assign dx = i_st.y >>> STEP;
    assign dy = i_st.x >>> STEP;

    always_comb begin
        n_st = i_st;
        // Points on the x axis already carry their final radius and angle.
        if (!i_st.axis) begin
            if (!i_st.y[XW-1]) begin
                n_st.x   = i_st.x + dx;
                n_st.y   = i_st.y - dy;
                n_st.ang = i_st.ang + ATAN;
            end else begin
                n_st.x   = i_st.x - dx;
                n_st.y   = i_st.y + dy;
                n_st.ang = i_st.ang - ATAN;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st.valid <= 1'b0;
        end else if (i_en) begin
            r_st   <= n_st;
            r_side <= i_side;
        end
    end

    assign o_st   = r_st;
    assign o_side = r_side;

endmodule

[hw/rtl/p2s_mul_round.sv]
// Two-stage signed multiply with round-half-up right shift, split into two partial products.
module p2s_mul_round #(
    parameter int AW = 47,
    parameter int BW = 32,
    parameter int K  = 30
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic signed [AW-1:0]     i_a,
    input  logic signed [BW-1:0]     i_b,
    output logic signed [AW+BW-K-1:0] o_p
);
    localparam int HL = AW / 2;
    localparam int HW = AW - HL;
    localparam int SW = AW + BW;
    localparam logic signed [SW-1:0] ROUND = {{(SW-1){1'b0}}, 1'b1} << (K - 1);

    logic signed [HL+BW:0]   n_lo;
    logic signed [HW+BW-1:0] n_hi;
    logic signed [HL+BW:0]   r_lo;
    logic signed [HW+BW-1:0] r_hi;
    logic signed [SW-1:0]    sum;
    logic signed [SW-K-1:0]  r_p;

    assign n_lo = $signed({1'b0, i_a[HL-1:0]}) * i_b;
    assign n_hi = $signed(i_a[AW-1:HL]) * i_b;
    assign sum  = (SW'(r_hi) <<< HL) + SW'(r_lo) + ROUND;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lo <= n_lo;
            r_hi <= n_hi;
            r_p  <= sum[SW-1:K];
        end
    end

    assign o_p = r_p;

endmodule
